### rtl/sfx_pkg.sv
// shared types, constants and control structs for the sound-effect voice and mixer
`default_nettype none

package sfx_pkg;

    // phase accumulator width of the blip oscillator (16 to 32)
    localparam int PHASE_BITS = 32;

    localparam int SAMPLE_W = 16;
    localparam int VOICE_W  = 12;
    localparam int LEN_W    = 16;
    localparam int STEP_W   = 32;
    localparam int NOISE_W  = 15;

    // full voice level and its width
    localparam int                 AMP_W     = 11;
    localparam logic [AMP_W-1:0]   VOICE_AMP = AMP_W'(2000);

    // fade numerator is amp * remaining; quotient stays below 2^AMP_W
    localparam int NUM_W       = AMP_W + LEN_W;
    localparam int DIV_STEPS   = AMP_W;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

    // register reset values
    localparam logic [STEP_W-1:0] PULSE_STEP_RESET   = STEP_W'(101920256);
    localparam logic [LEN_W-1:0]  PULSE_LENGTH_RESET = LEN_W'(3150);
    localparam logic [LEN_W-1:0]  NOISE_LENGTH_RESET = LEN_W'(2450);
    localparam logic [LEN_W-1:0]  FADE_LENGTH_RESET  = LEN_W'(4411);
    localparam logic [NOISE_W-1:0] NOISE_SEED        = NOISE_W'(1);

    // input command codes
    localparam logic CMD_TICK    = 1'b0;
    localparam logic CMD_TRIGGER = 1'b1;

    // effect kinds
    localparam logic KIND_BLIP  = 1'b0;
    localparam logic KIND_NOISE = 1'b1;

    typedef enum logic [1:0] {
        CFG_PULSE_STEP   = 2'd0,
        CFG_PULSE_LENGTH = 2'd1,
        CFG_NOISE_LENGTH = 2'd2,
        CFG_FADE_LENGTH  = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic                        command;
        logic signed [SAMPLE_W-1:0]  music_sample;
        logic                        effect_kind;
    } in_word_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0]  mixed_sample;
        logic signed [VOICE_W-1:0]   voice_level;
        logic                        voice_active;
    } out_word_t;

    // controller to datapath
    typedef struct packed {
        logic accept_trigger;
        logic accept_tick;
        logic load_num;
        logic div_step;
        logic out_load;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic needs_div;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

### rtl/sfx_voice_and_mixer.sv
// top level of the sound-effect voice and music mixer
`default_nettype none

// sound-effect voice mixed into a music sample stream
// input channel: in_valid / in_stall carry one in_word; command selects a
//   trigger (starts a blip or noise voice, gives no output word) or a tick
//   (one music sample, gives exactly one output word)
// output channel: out_valid / out_stall carry out_word with the mixed sample,
//   the faded voice level and whether the voice still sounds
// config port: cfg_wr_en with cfg_index and cfg_data writes one register in a
//   cycle; write only while the block is idle
// sequence: a trigger is accepted while idle and the block stays idle; a tick passes
//   accept, numerator load and output load at full level or with the voice off, and
//   accept, numerator load, 11 steps of the restoring fade divider (one quotient bit
//   a step) and output load while fading; out_valid is registered from the output load
// a result waits in the output register while the next word is accepted; if
//   it is still stalled when the next result is ready, the block holds that
//   result and stalls its input
// reset: registers take their default values, the voice is off, the noise
//   register is seeded to one and no output word is valid
module sfx_voice_and_mixer (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  sfx_pkg::cfg_index_t   cfg_index,
    input  logic [31:0]           cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  sfx_pkg::in_word_t     in_word,
    output logic                  out_valid,
    input  logic                  out_stall,
    output sfx_pkg::out_word_t    out_word
);
    import sfx_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    // sequencing of accept, divide and output load
    sfx_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_command (in_word.command),
        .in_stall   (in_stall),
        .status     (status),
        .cmd        (cmd)
    );

    // voice state, fade divider, mixer and output register
    sfx_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_word   (in_word),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word)
    );

endmodule

`default_nettype wire

### rtl/sfx_ctrl.sv
// controller state machine sequencing accept, fade divide and output load
`default_nettype none

module sfx_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_command,
    output logic                  in_stall,
    input  sfx_pkg::dp_status_t   status,
    output sfx_pkg::dp_cmd_t      cmd
);
    import sfx_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIVIDE,
        ST_DONE
    } state_t;

    state_t               state_reg;
    state_t               state_next;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_CNT_W-1:0] cnt_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_command == CMD_TRIGGER)
                    begin
                        cmd.accept_trigger = 1'b1;
                    end
                    else
                    begin
                        cmd.accept_tick = 1'b1;
                        state_next      = ST_LOAD;
                    end
                end
            end
            ST_LOAD:
            begin
                cmd.load_num = 1'b1;
                cnt_next     = '0;
                state_next   = status.needs_div ? ST_DIVIDE : ST_DONE;
            end
            ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign in_stall = (state_reg != ST_IDLE);

endmodule

`default_nettype wire

### rtl/sfx_dp.sv
// datapath: registers, voice state, serial fade divider, mixer and output register
`default_nettype none

module sfx_dp (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  sfx_pkg::cfg_index_t    cfg_index,
    input  logic [31:0]            cfg_data,
    input  sfx_pkg::in_word_t      in_word,
    input  sfx_pkg::dp_cmd_t       cmd,
    output sfx_pkg::dp_status_t    status,
    output logic                   out_valid,
    input  logic                   out_stall,
    output sfx_pkg::out_word_t     out_word
);
    import sfx_pkg::*;

    // configuration
    logic [STEP_W-1:0] pulse_step_reg;
    logic [LEN_W-1:0]  pulse_length_reg;
    logic [LEN_W-1:0]  noise_length_reg;
    logic [LEN_W-1:0]  fade_length_reg;

    // voice state
    logic                  active_reg;
    logic                  kind_reg;
    logic [LEN_W-1:0]      remaining_reg;
    logic [PHASE_BITS-1:0] phase_reg;
    logic [NOISE_W-1:0]    noise_reg;

    // per-tick working registers
    logic                       voice_on_reg;
    logic                       full_reg;
    logic                       positive_reg;
    logic signed [SAMPLE_W-1:0] music_reg;
    logic [LEN_W-1:0]           div_rem_reg;
    logic [AMP_W-1:0]           div_quo_reg;

    logic      out_valid_reg;
    out_word_t out_word_reg;

    // tick arithmetic
    logic                  voice_on;
    logic [LEN_W-1:0]      rem_dec;
    logic [PHASE_BITS-1:0] phase_inc;
    logic [PHASE_BITS-1:0] phase_next;
    logic [NOISE_W-1:0]    noise_src;
    logic [NOISE_W-1:0]    noise_next;
    logic [NUM_W-1:0]      product;
    logic [LEN_W:0]        trial;
    logic                  trial_ge;

    logic [AMP_W-1:0]           mag;
    logic signed [VOICE_W-1:0]  voice;
    logic signed [SAMPLE_W+1:0] sum;
    logic signed [SAMPLE_W+1:0] quarter;
    logic signed [SAMPLE_W-1:0] mixed;

    assign voice_on   = active_reg && (remaining_reg != '0);
    assign rem_dec    = remaining_reg - 1'b1;
    assign phase_inc  = pulse_step_reg[STEP_W-1 -: PHASE_BITS];
    assign phase_next = phase_reg + phase_inc;
    assign noise_src  = (noise_reg == '0) ? NOISE_SEED : noise_reg;
    assign noise_next = {noise_src[0] ^ noise_src[1], noise_src[NOISE_W-1:1]};

    assign product  = NUM_W'(VOICE_AMP) * NUM_W'(remaining_reg);
    assign trial    = {div_rem_reg, div_quo_reg[AMP_W-1]};
    assign trial_ge = (trial >= {1'b0, fade_length_reg});

    // fade magnitude and sign
    always_comb
    begin
        if (!voice_on_reg)
        begin
            mag = '0;
        end
        else if (full_reg)
        begin
            mag = VOICE_AMP;
        end
        else
        begin
            mag = div_quo_reg;
        end
        voice = positive_reg ? signed'({1'b0, mag}) : -signed'({1'b0, mag});
    end

    // mix: quarter with truncation toward zero, then clamp
    always_comb
    begin
        sum     = (SAMPLE_W+2)'(music_reg) + (SAMPLE_W+2)'(voice);
        quarter = (sum + ((sum < 0) ? (SAMPLE_W+2)'(3) : (SAMPLE_W+2)'(0))) >>> 2;
        if (quarter > (SAMPLE_W+2)'(32767))
        begin
            mixed = 16'sh7fff;
        end
        else if (quarter < -(SAMPLE_W+2)'(32768))
        begin
            mixed = 16'sh8000;
        end
        else
        begin
            mixed = quarter[SAMPLE_W-1:0];
        end
    end

    assign status.needs_div = voice_on_reg && !full_reg;
    assign status.out_free  = !out_valid_reg || !out_stall;

    // configuration and voice state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pulse_step_reg   <= PULSE_STEP_RESET;
            pulse_length_reg <= PULSE_LENGTH_RESET;
            noise_length_reg <= NOISE_LENGTH_RESET;
            fade_length_reg  <= FADE_LENGTH_RESET;
            active_reg       <= 1'b0;
            kind_reg         <= KIND_BLIP;
            remaining_reg    <= '0;
            phase_reg        <= '0;
            noise_reg        <= NOISE_SEED;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    CFG_PULSE_STEP:   pulse_step_reg   <= cfg_data[STEP_W-1:0];
                    CFG_PULSE_LENGTH: pulse_length_reg <= cfg_data[LEN_W-1:0];
                    CFG_NOISE_LENGTH: noise_length_reg <= cfg_data[LEN_W-1:0];
                    CFG_FADE_LENGTH:  fade_length_reg  <= cfg_data[LEN_W-1:0];
                endcase
            end
            if (cmd.accept_trigger)
            begin
                active_reg    <= 1'b1;
                kind_reg      <= in_word.effect_kind;
                phase_reg     <= '0;
                noise_reg     <= NOISE_SEED;
                remaining_reg <= (in_word.effect_kind == KIND_NOISE) ?
                                 noise_length_reg : pulse_length_reg;
            end
            else if (cmd.accept_tick)
            begin
                if (voice_on)
                begin
                    remaining_reg <= rem_dec;
                    active_reg    <= (rem_dec != '0);
                    if (kind_reg == KIND_NOISE)
                    begin
                        noise_reg <= noise_next;
                    end
                    else
                    begin
                        phase_reg <= phase_next;
                    end
                end
                else
                begin
                    active_reg <= 1'b0;
                end
            end
        end
    end

    // per-tick working registers, divider and output word, no reset needed
    always_ff @(posedge clk)
    begin
        if (cmd.accept_tick)
        begin
            music_reg    <= in_word.music_sample;
            voice_on_reg <= voice_on;
            full_reg     <= (rem_dec >= fade_length_reg);
            positive_reg <= (kind_reg == KIND_NOISE) ? noise_next[0]
                                                     : !phase_next[PHASE_BITS-1];
        end
        if (cmd.load_num)
        begin
            // upper part is already below the divisor since quotient < 2^AMP_W
            div_rem_reg <= product[NUM_W-1:AMP_W];
            div_quo_reg <= product[AMP_W-1:0];
        end
        else if (cmd.div_step)
        begin
            div_rem_reg <= trial_ge ? LEN_W'(trial - {1'b0, fade_length_reg})
                                    : trial[LEN_W-1:0];
            div_quo_reg <= {div_quo_reg[AMP_W-2:0], trial_ge};
        end
        if (cmd.out_load)
        begin
            out_word_reg.mixed_sample <= mixed;
            out_word_reg.voice_level  <= voice;
            out_word_reg.voice_active <= active_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule

`default_nettype wire

### tb/sfx_voice_and_mixer_tb.sv
// testbench for the sound-effect voice and mixer: directed table, then randomized phases
`timescale 1ns / 100ps

module sfx_voice_and_mixer_tb;

    import sfx_pkg::*;

    // pacing of the two channels
    typedef enum logic [1:0] {
        PACE_FREE,
        PACE_SENDER,
        PACE_RECEIVER,
        PACE_BOTH
    } pace_t;

    // one line of the directed table; known_res holds a hand-typed result
    typedef struct packed {
        in_word_t  word;
        logic      known;
        out_word_t known_res;
    } script_row_t;

    localparam int SETTLE_CYCLES = 20;     // longer than the slowest tick
    localparam int QUIET_LIMIT   = 4000;   // cycles with no handshake or register write before giving up
    localparam int PHASES        = 8;
    localparam int WORDS_PER_PHASE = 181;

    logic       clk;
    logic       rst_n;
    logic       cfg_wr_en;
    cfg_index_t cfg_index;
    logic [31:0] cfg_data;
    logic       in_valid;
    logic       in_stall;
    in_word_t   in_word;
    logic       out_valid;
    logic       out_stall = 1'b0;
    out_word_t  out_word;

    sfx_voice_and_mixer DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word)
    );

    // registers as the block should hold them
    logic [STEP_W-1:0] step_reg;
    logic [LEN_W-1:0]  pulse_len_reg;
    logic [LEN_W-1:0]  noise_len_reg;
    logic [LEN_W-1:0]  fade_len_reg;

    // voice state as the block should hold it
    logic                  voice_on;
    logic                  voice_kind;
    logic [LEN_W-1:0]      exp_remaining;
    logic [PHASE_BITS-1:0] blip_phase;
    logic [NOISE_W-1:0]    exp_noise;

    out_word_t mix_expect_q[$];
    int        mismatch_cnt = 0;
    int        quiet_cycles = 0;
    int        gap_pct   = 0;    // chance in 100 that the sender idles a cycle
    int        stall_pct = 0;    // chance in 100 that the receiver stalls a cycle

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // advance the voice by one word; a tick yields one mixed word, a trigger none
    function automatic void voice_mix_predict(input in_word_t w, output logic has_res,
                                              output out_word_t res);
        int                 music;
        int                 level;
        int                 mix;
        logic [31:0]        mag;
        logic [NOISE_W-1:0] seed;
        logic               pos;
        has_res = 1'b0;
        res     = '0;
        if (w.command == CMD_TRIGGER)
        begin
            // music is ignored on a trigger
            voice_on      = 1'b1;
            voice_kind    = w.effect_kind;
            blip_phase    = '0;
            exp_noise     = NOISE_SEED;
            exp_remaining = (w.effect_kind == KIND_NOISE) ? noise_len_reg : pulse_len_reg;
            return;
        end
        music = int'(w.music_sample);
        if (!voice_on || exp_remaining == '0)
        begin
            // silent voice, music still goes through
            voice_on = 1'b0;
            level    = 0;
        end
        else
        begin
            exp_remaining = exp_remaining - 1'b1;
            if (voice_kind == KIND_NOISE)
            begin
                seed      = (exp_noise == '0) ? NOISE_W'(1) : exp_noise;
                exp_noise = {seed[0] ^ seed[1], seed[NOISE_W-1:1]};
                pos       = exp_noise[0];
            end
            else
            begin
                blip_phase = blip_phase + step_reg[STEP_W-1 -: PHASE_BITS];
                pos        = !blip_phase[PHASE_BITS-1];
            end
            // linear fade over the last fade_length samples
            if (exp_remaining >= fade_len_reg)
                mag = 32'd2000;
            else
                mag = 32'd2000 * {16'd0, exp_remaining} / {16'd0, fade_len_reg};
            level = pos ? int'(mag) : -int'(mag);
            if (exp_remaining == '0)
                voice_on = 1'b0;
        end
        mix = (music + level) / 4;
        if (mix > 32767)
            mix = 32767;
        if (mix < -32768)
            mix = -32768;
        has_res          = 1'b1;
        res.mixed_sample = mix[SAMPLE_W-1:0];
        res.voice_level  = level[VOICE_W-1:0];
        res.voice_active = voice_on;
    endfunction

    function automatic script_row_t script_line(input logic cmd, input int music,
                                                input logic kind, input logic known,
                                                input int mix, input int level,
                                                input logic active);
        script_row_t r;
        r.word.command                = cmd;
        r.word.music_sample           = music[SAMPLE_W-1:0];
        r.word.effect_kind            = kind;
        r.known                       = known;
        r.known_res.mixed_sample      = mix[SAMPLE_W-1:0];
        r.known_res.voice_level       = level[VOICE_W-1:0];
        r.known_res.voice_active      = active;
        return r;
    endfunction

    // present one word until accepted, then log what it should produce
    task automatic send_word(input in_word_t w, input logic known, input out_word_t known_res);
        logic      has_res;
        out_word_t res;
        while (gap_pct != 0 && $urandom_range(99) < gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        voice_mix_predict(w, has_res, res);
        if (has_res)
            mix_expect_q.push_back(known ? known_res : res);
    endtask

    // hold the input, let every expected word drain, then allow for a word still in flight
    task automatic settle();
        in_valid <= 1'b0;
        while (mix_expect_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // one register write; the caller drops the enable after the last one
    task automatic put_reg(input cfg_index_t idx, input logic [31:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            CFG_PULSE_STEP:   step_reg      = val;
            CFG_PULSE_LENGTH: pulse_len_reg = val[LEN_W-1:0];
            CFG_NOISE_LENGTH: noise_len_reg = val[LEN_W-1:0];
            CFG_FADE_LENGTH:  fade_len_reg  = val[LEN_W-1:0];
            default: ;
        endcase
    endtask

    // receiver back-pressure
    always @(posedge clk)
    begin
        out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    end

    // result checker: every accepted word against the oldest expectation
    always @(posedge clk)
    begin
        out_word_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (mix_expect_q.size() == 0)
            begin
                $display("%0t: unexpected word mixed=%0d level=%0d active=%0b", $time,
                         out_word.mixed_sample, out_word.voice_level, out_word.voice_active);
                mismatch_cnt = mismatch_cnt + 1;
            end
            else
            begin
                want = mix_expect_q.pop_front();
                if (out_word.mixed_sample !== want.mixed_sample)
                begin
                    $display("%0t: mixed_sample expected %0d got %0d", $time,
                             want.mixed_sample, out_word.mixed_sample);
                    mismatch_cnt = mismatch_cnt + 1;
                end
                if (out_word.voice_level !== want.voice_level)
                begin
                    $display("%0t: voice_level expected %0d got %0d", $time,
                             want.voice_level, out_word.voice_level);
                    mismatch_cnt = mismatch_cnt + 1;
                end
                if (out_word.voice_active !== want.voice_active)
                begin
                    $display("%0t: voice_active expected %0b got %0b", $time,
                             want.voice_active, out_word.voice_active);
                    mismatch_cnt = mismatch_cnt + 1;
                end
            end
        end
    end

    // watchdog: too long without any handshake or register write means a hang
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
            $display("sfx_voice_and_mixer_tb: errors");
            $finish;
        end
    end

    initial
    begin
        script_row_t script[$];
        in_word_t    w;
        logic [31:0] st;
        logic [31:0] pl;
        logic [31:0] nl;
        logic [31:0] fl;
        pace_t       pace;
        int          p;
        int          n;

        // every input known from time zero, reset held low
        rst_n     = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = CFG_PULSE_STEP;
        cfg_data  = '0;
        in_valid  = 1'b0;
        in_word   = '0;

        // predictor starts at the reset defaults
        step_reg      = PULSE_STEP_RESET;
        pulse_len_reg = PULSE_LENGTH_RESET;
        noise_len_reg = NOISE_LENGTH_RESET;
        fade_len_reg  = FADE_LENGTH_RESET;
        voice_on      = 1'b0;
        voice_kind    = KIND_BLIP;
        exp_remaining = '0;
        blip_phase    = '0;
        exp_noise     = NOISE_SEED;

        // directed table, default registers
        // voice off after reset: level 0, mix is music/4 truncated toward zero
        script.push_back(script_line(CMD_TICK,     32767, KIND_BLIP,  1'b1,  8191, 0, 1'b0));
        script.push_back(script_line(CMD_TICK,    -32768, KIND_NOISE, 1'b1, -8192, 0, 1'b0));
        script.push_back(script_line(CMD_TICK,        -3, KIND_BLIP,  1'b1,     0, 0, 1'b0));
        script.push_back(script_line(CMD_TICK,         7, KIND_NOISE, 1'b1,     1, 0, 1'b0));
        // blip, music on the trigger is ignored
        script.push_back(script_line(CMD_TRIGGER, 32'h1234, KIND_BLIP, 1'b0, 0, 0, 1'b0));
        script.push_back(script_line(CMD_TICK,         0, KIND_BLIP,  1'b0, 0, 0, 1'b0));
        script.push_back(script_line(CMD_TICK,     32767, KIND_NOISE, 1'b0, 0, 0, 1'b0));
        script.push_back(script_line(CMD_TICK,    -32768, KIND_BLIP,  1'b0, 0, 0, 1'b0));
        script.push_back(script_line(CMD_TICK,        -1, KIND_NOISE, 1'b0, 0, 0, 1'b0));
        // noise retrigger over a running blip
        script.push_back(script_line(CMD_TRIGGER, -32768, KIND_NOISE, 1'b0, 0, 0, 1'b0));
        script.push_back(script_line(CMD_TICK,       100, KIND_BLIP,  1'b0, 0, 0, 1'b0));
        script.push_back(script_line(CMD_TICK,      -100, KIND_BLIP,  1'b0, 0, 0, 1'b0));
        script.push_back(script_line(CMD_TICK,     32767, KIND_NOISE, 1'b0, 0, 0, 1'b0));
        script.push_back(script_line(CMD_TICK,    -32768, KIND_NOISE, 1'b0, 0, 0, 1'b0));
        // blip retrigger over running noise
        script.push_back(script_line(CMD_TRIGGER,  32767, KIND_BLIP,  1'b0, 0, 0, 1'b0));
        script.push_back(script_line(CMD_TICK,         0, KIND_NOISE, 1'b0, 0, 0, 1'b0));
        script.push_back(script_line(CMD_TRIGGER,      0, KIND_NOISE, 1'b0, 0, 0, 1'b0));
        script.push_back(script_line(CMD_TICK,         0, KIND_BLIP,  1'b0, 0, 0, 1'b0));

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[i])
            send_word(script[i].word, script[i].known, script[i].known_res);

        // random phases, each with its own register setting and pacing
        for (p = 0; p < PHASES; p++)
        begin
            settle();
            case (p)
                0:
                begin
                    // one-sample voices, blip step of all ones
                    st = 32'hFFFF_FFFF; pl = 1; nl = 1; fl = 1;
                    pace = PACE_FREE;
                end
                1:
                begin
                    // longest voices, frozen phase, fade over the whole length
                    st = 32'h0; pl = 32'hFFFF; nl = 32'hFFFF; fl = 32'hFFFF;
                    pace = PACE_SENDER;
                end
                2:
                begin
                    // zero lengths die on the first tick; zero fade keeps full level
                    st = 32'h8000_0000; pl = 0; nl = 0; fl = 0;
                    pace = PACE_RECEIVER;
                end
                3:
                begin
                    st = $urandom; pl = $urandom_range(40, 1); nl = $urandom_range(40, 1);
                    fl = $urandom_range(60, 1);
                    pace = PACE_BOTH;
                end
                4:
                begin
                    st = 32'h1; pl = 20; nl = 25; fl = 32'hFFFF;
                    pace = PACE_FREE;
                end
                default:
                begin
                    st = $urandom; pl = $urandom_range(60, 1); nl = $urandom_range(60, 1);
                    fl = $urandom_range(80, 1);
                    pace = (p == 5) ? PACE_SENDER : (p == 6) ? PACE_RECEIVER : PACE_BOTH;
                end
            endcase
            put_reg(CFG_PULSE_STEP,   st);
            put_reg(CFG_PULSE_LENGTH, pl);
            put_reg(CFG_NOISE_LENGTH, nl);
            put_reg(CFG_FADE_LENGTH,  fl);
            cfg_wr_en <= 1'b0;

            case (pace)
                PACE_SENDER:   begin gap_pct = 82; stall_pct = 0;  end
                PACE_RECEIVER: begin gap_pct = 0;  stall_pct = 82; end
                PACE_BOTH:     begin gap_pct = 30; stall_pct = 30; end
                default:       begin gap_pct = 0;  stall_pct = 0;  end
            endcase

            for (n = 0; n < WORDS_PER_PHASE; n++)
            begin
                // mid-phase the sender holds off until every result is back
                if (n == WORDS_PER_PHASE / 2 && mix_expect_q.size() != 0)
                begin
                    in_valid <= 1'b0;
                    while (mix_expect_q.size() != 0)
                        @(posedge clk);
                end
                // mostly ticks, with triggers sprinkled in so voices start,
                // fade out and get cut short
                w.command     = ($urandom_range(99) < 7) ? CMD_TRIGGER : CMD_TICK;
                w.effect_kind = 1'($urandom_range(1));
                case ($urandom_range(15))
                    0:       w.music_sample = 16'sh7FFF;
                    1:       w.music_sample = 16'sh8000;
                    2:       w.music_sample = '0;
                    3:       w.music_sample = '1;
                    default: w.music_sample = 16'($urandom);
                endcase
                send_word(w, 1'b0, '0);
            end
        end

        settle();
        if (mismatch_cnt == 0)
            $display("sfx_voice_and_mixer_tb: clean");
        else
            $display("sfx_voice_and_mixer_tb: errors");
        $finish;
    end

endmodule

### sim.f
rtl/sfx_pkg.sv
rtl/sfx_ctrl.sv
rtl/sfx_dp.sv
rtl/sfx_voice_and_mixer.sv
tb/sfx_voice_and_mixer_tb.sv
